FILE: design/svo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Synth voice oscillator package
// Widths, codes, state types and the constant tables of the voice: note to
// phase increment, velocity to level, and the quarter-wave sine.
// ----------------------------------------------------------------------------
package svo_pkg;

	localparam int SAMPLE_RATE      = 48000;
	localparam int PHASE_BITS       = 32;
	localparam int SINE_TABLE_DEPTH = 256;
	localparam int SINE_ADDR_W      = $clog2(SINE_TABLE_DEPTH);

	localparam int OP_W       = 2;
	localparam int NOTE_W     = 7;
	localparam int VEL_W      = 7;
	localparam int NOTE_COUNT = 1 << NOTE_W;
	localparam int VEL_COUNT  = 1 << VEL_W;
	localparam int SAMPLE_W   = 16;
	localparam int WAVE_W     = 2;
	localparam int GAIN_W     = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = GAIN_W;

	localparam int AMP_W     = 15;
	localparam int MAG_W     = 16;
	localparam int LEVEL_W   = 16;
	localparam int ENV_W     = 16;
	localparam int ENV_EFF_W = ENV_W + 1;
	localparam int PROD_W    = MAG_W + LEVEL_W + ENV_EFF_W + GAIN_W;
	localparam int ROUND_SHIFT = 40;
	localparam int R_W       = PROD_W - ROUND_SHIFT;

	localparam int DIGIT_W      = 4;
	localparam int MPLIER_W     = ENV_EFF_W;
	localparam int LEVEL_DIGITS = (LEVEL_W + DIGIT_W - 1) / DIGIT_W;
	localparam int ENV_DIGITS   = (ENV_EFF_W + DIGIT_W - 1) / DIGIT_W;
	localparam int GAIN_DIGITS  = (GAIN_W + DIGIT_W - 1) / DIGIT_W;
	localparam int DECAY_DIGITS = (ENV_W + DIGIT_W - 1) / DIGIT_W;
	localparam int CNT_W        = $clog2(ENV_DIGITS);

	localparam logic [ENV_W-1:0]     ENV_START  = 16'd65535;
	localparam logic [ENV_W-1:0]     ENV_DECAY  = 16'd65012;
	localparam logic [ENV_W-1:0]     ENV_FLOOR  = 16'd328;
	localparam logic [ENV_EFF_W-1:0] ENV_UNITY  = 17'h10000;
	localparam logic [PROD_W-1:0]    ENV_HALF   = PROD_W'(1) << (ENV_W - 1);
	localparam logic [PROD_W-1:0]    ROUND_HALF = PROD_W'(1) << (ROUND_SHIFT - 1);
	localparam logic [GAIN_W-1:0]    GAIN_RESET = 9'd205;

	localparam logic [MAG_W-1:0]    MAG_HALF   = 16'h8000;
	localparam logic [MAG_W-1:0]    MAG_MAX    = 16'h7FFF;
	localparam logic [R_W-1:0]      R_POS_MAX  = R_W'(32767);
	localparam logic [R_W-1:0]      R_NEG_MAX  = R_W'(32768);
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;

	typedef enum logic [OP_W-1:0] {
		OP_TICK,
		OP_NOTE_ON,
		OP_NOTE_OFF,
		OP_NOTE_KILL
	} op_t;

	typedef enum logic [WAVE_W-1:0] {
		WAVE_SINE,
		WAVE_SAW,
		WAVE_SQUARE,
		WAVE_TRIANGLE
	} wave_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WAVEFORM,
		CFG_OUTPUT_GAIN
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ROUND,
		ST_ENV,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		PASS_LEVEL,
		PASS_ENV,
		PASS_GAIN,
		PASS_DECAY
	} pass_t;

	localparam logic [63:0] FREQ0_Q20 = 64'd8572947;
	localparam logic [63:0] S_C1 = 64'd1686629713;
	localparam logic [63:0] S_C3 = 64'd693598668;
	localparam logic [63:0] S_C5 = 64'd85569306;
	localparam logic [63:0] S_C7 = 64'd5026994;
	localparam logic [63:0] S_C9 = 64'd172272;
	localparam logic [63:0] LEVEL_NUM = 64'd1441792;
	localparam logic [63:0] LEVEL_DEN = 64'd12700;

	localparam logic [16:0] SEMITONE_Q16 [12] = '{
		17'd65536, 17'd69433, 17'd73562, 17'd77936, 17'd82570, 17'd87480,
		17'd92682, 17'd98193, 17'd104032, 17'd110218, 17'd116772, 17'd123715
	};

	typedef logic [PHASE_BITS-1:0] step_tab_t [NOTE_COUNT];
	typedef logic [LEVEL_W-1:0]    level_tab_t [VEL_COUNT];
	typedef logic [AMP_W-1:0]      sine_tab_t [SINE_TABLE_DEPTH];

	function automatic step_tab_t gen_step_table();
		step_tab_t   tab;
		logic [63:0] hz;
		logic [63:0] s;
		for (int n = 0; n < NOTE_COUNT; n++) begin
			hz = (FREQ0_Q20 * 64'(SEMITONE_Q16[n % 12])) << (n / 12);
			hz = (hz + (64'd1 << 19)) >> 20;
			s = ((hz << (PHASE_BITS - 16)) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE);
			tab[n] = s[PHASE_BITS-1:0];
		end
		return tab;
	endfunction

	function automatic level_tab_t gen_level_table();
		level_tab_t  tab;
		logic [63:0] v;
		for (int i = 0; i < VEL_COUNT; i++) begin
			v = (64'(i) * LEVEL_NUM + 64'd6350) / LEVEL_DEN;
			tab[i] = v[LEVEL_W-1:0];
		end
		return tab;
	endfunction

	function automatic sine_tab_t gen_sine_table();
		sine_tab_t   tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] amp;
		for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
			x = (64'(2 * i + 1) << 29) / 64'(SINE_TABLE_DEPTH);
			x2 = (x * x) >> 30;
			t = S_C7 - ((x2 * S_C9) >> 30);
			t = S_C5 - ((x2 * t) >> 30);
			t = S_C3 - ((x2 * t) >> 30);
			t = S_C1 - ((x2 * t) >> 30);
			s = (x * t) >> 30;
			amp = (s * 64'd32767 + (64'd1 << 29)) >> 30;
			if (amp > 64'd32767) begin
				amp = 64'd32767;
			end
			tab[i] = amp[AMP_W-1:0];
		end
		return tab;
	endfunction

	localparam step_tab_t  STEP_TABLE  = gen_step_table();
	localparam level_tab_t LEVEL_TABLE = gen_level_table();
	localparam sine_tab_t  SINE_TABLE  = gen_sine_table();

endpackage

FILE: design/svo_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice request channel
// Valid/ready channel that carries one voice event per beat.
// ----------------------------------------------------------------------------
interface svo_req_if;
	logic                       valid;
	logic                       ready;
	logic [svo_pkg::OP_W-1:0]   op;
	logic [svo_pkg::NOTE_W-1:0] note;
	logic [svo_pkg::VEL_W-1:0]  velocity;

	modport source (output valid, output op, output note, output velocity, input ready);
	modport sink (input valid, input op, input note, input velocity, output ready);
endinterface

FILE: design/svo_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice result channel
// Valid/ready channel that carries one audio sample per beat.
// ----------------------------------------------------------------------------
interface svo_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [svo_pkg::SAMPLE_W-1:0] sample;
	logic                                active;

	modport source (output valid, output sample, output active, input ready);
	modport sink (input valid, input sample, input active, output ready);
endinterface

FILE: design/synth_voice_oscillator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Synth voice oscillator core
// One synthesizer voice: phase accumulator, four waveforms, level, release
// envelope and output gain, scaled through a 4-bit digit-serial multiplier.
// ----------------------------------------------------------------------------
//  Channel  Dir  Beat                    Payload
//  req      in   one voice event         op, note, velocity
//  rsp      out  one sample per tick     sample, active
//  cfg      in   one register write      cfg_idx, cfg_wdata
//
//  Note events are taken in the idle state. A tick of a sounding voice runs
//  the level, envelope and gain passes, and a decay pass while the release envelope runs.
//  The passes share one 4-bit digit-serial multiplier: 12 digit
//  steps for level, envelope and gain, 4 more for the envelope decay.
//  The result register frees the core while a sample waits on rsp; a second
//  sample waits in the core until the first beat is taken.
//  Reset is asynchronous and leaves the voice idle, waveform sine, gain 205.
// ----------------------------------------------------------------------------
module synth_voice_oscillator_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [svo_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [svo_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	svo_req_if.sink                          req,
	svo_rsp_if.source                        rsp
);

	svo_pkg::state_t state_q;
	svo_pkg::state_t state_d;
	svo_pkg::pass_t  pass_q;
	logic [svo_pkg::CNT_W-1:0] cnt_q;

	logic [svo_pkg::PHASE_BITS-1:0] phase_acc_q;
	logic [svo_pkg::PHASE_BITS-1:0] phase_step_q;
	logic [svo_pkg::ENV_W-1:0]      release_env_q;
	logic [svo_pkg::LEVEL_W-1:0]    note_level_q;
	logic                           voice_on_q;
	svo_pkg::wave_t                 waveform_q;
	logic [svo_pkg::GAIN_W-1:0]     output_gain_q;

	logic [svo_pkg::PROD_W-1:0]   acc_q;
	logic [svo_pkg::PROD_W-1:0]   mcand_q;
	logic [svo_pkg::MPLIER_W-1:0] mplier_q;
	logic                         neg_q;
	logic [svo_pkg::SAMPLE_W-1:0] res_sample_q;

	logic                         rsp_valid_q;
	logic [svo_pkg::SAMPLE_W-1:0] rsp_sample_q;
	logic                         rsp_active_q;

	logic                              req_ready;
	logic                              req_accept;
	logic                              tick_accept;
	logic                              rsp_load;
	logic                              last_digit;
	svo_pkg::op_t                      op;
	logic [svo_pkg::PHASE_BITS+31:0]   phase_ext;
	logic [31:0]                       p32;
	logic [svo_pkg::SINE_ADDR_W-1:0]   sine_idx;
	logic [16:0]                       tri_d;
	logic [svo_pkg::MAG_W-1:0]         wave_mag;
	logic                              wave_neg;
	logic [svo_pkg::DIGIT_W-1:0]       digit;
	logic [svo_pkg::PROD_W-1:0]        acc_nx;
	logic [svo_pkg::ENV_EFF_W-1:0]     env_eff;
	logic [svo_pkg::PROD_W-1:0]        rnd;
	logic [svo_pkg::R_W-1:0]           r_mag;
	logic [svo_pkg::R_W-1:0]           r_neg;
	logic [svo_pkg::SAMPLE_W-1:0]      round_sample;
	logic [svo_pkg::ENV_W-1:0]         decayed;

	assign op          = svo_pkg::op_t'(req.op);
	assign req_accept  = req.valid && req_ready;
	assign tick_accept = req_accept && (op == svo_pkg::OP_TICK);
	assign last_digit  = (cnt_q == '0);
	assign rsp_load    = (state_q == svo_pkg::ST_FIN) && (!rsp_valid_q || rsp.ready);

	// The top 32 bits of the phase drive the waveform, whatever PHASE_BITS is.
	assign phase_ext = {phase_acc_q, 32'd0};
	assign p32       = phase_ext[svo_pkg::PHASE_BITS+31 -: 32];
	assign sine_idx  = p32[30] ? ~p32[29 -: svo_pkg::SINE_ADDR_W]
	                           : p32[29 -: svo_pkg::SINE_ADDR_W];
	assign tri_d     = p32[31] ? {1'b0, p32[30:15]} : (17'h10000 - {1'b0, p32[30:15]});

	always_comb begin
		wave_mag = '0;
		wave_neg = 1'b0;
		case (waveform_q)
			svo_pkg::WAVE_SINE: begin
				wave_mag = {1'b0, svo_pkg::SINE_TABLE[sine_idx]};
				wave_neg = p32[31];
			end
			svo_pkg::WAVE_SAW: begin
				wave_neg = !p32[31];
				wave_mag = p32[31] ? {1'b0, p32[30:16]} : (svo_pkg::MAG_HALF - {1'b0, p32[30:16]});
			end
			svo_pkg::WAVE_SQUARE: begin
				wave_neg = p32[31];
				wave_mag = svo_pkg::MAG_MAX;
			end
			default: begin
				if (tri_d[16]) begin
					wave_mag = svo_pkg::MAG_MAX;
				end else if (tri_d[15]) begin
					wave_mag = {1'b0, tri_d[14:0]};
				end else begin
					wave_neg = 1'b1;
					wave_mag = svo_pkg::MAG_HALF - {1'b0, tri_d[14:0]};
				end
			end
		endcase
	end

	assign digit   = mplier_q[svo_pkg::DIGIT_W-1:0];
	assign acc_nx  = acc_q + mcand_q * {{(svo_pkg::PROD_W - svo_pkg::DIGIT_W){1'b0}}, digit};
	assign env_eff = (release_env_q == '0) ? svo_pkg::ENV_UNITY : {1'b0, release_env_q};
	assign decayed = acc_q[2*svo_pkg::ENV_W-1:svo_pkg::ENV_W];

	assign rnd   = acc_q + svo_pkg::ROUND_HALF;
	assign r_mag = rnd[svo_pkg::PROD_W-1:svo_pkg::ROUND_SHIFT];
	assign r_neg = ~r_mag + svo_pkg::R_W'(1);

	always_comb begin
		if (!neg_q) begin
			round_sample = (r_mag > svo_pkg::R_POS_MAX) ? svo_pkg::SAMPLE_MAX
			                                            : r_mag[svo_pkg::SAMPLE_W-1:0];
		end else begin
			round_sample = (r_mag > svo_pkg::R_NEG_MAX) ? svo_pkg::SAMPLE_MIN
			                                            : r_neg[svo_pkg::SAMPLE_W-1:0];
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		unique case (state_q)
			svo_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (tick_accept) begin
					state_d = voice_on_q ? svo_pkg::ST_MUL : svo_pkg::ST_FIN;
				end
			end
			svo_pkg::ST_MUL: begin
				if (last_digit && pass_q == svo_pkg::PASS_GAIN) begin
					state_d = svo_pkg::ST_ROUND;
				end else if (last_digit && pass_q == svo_pkg::PASS_DECAY) begin
					state_d = svo_pkg::ST_ENV;
				end
			end
			svo_pkg::ST_ROUND: begin
				state_d = (release_env_q != '0) ? svo_pkg::ST_MUL : svo_pkg::ST_FIN;
			end
			svo_pkg::ST_ENV: begin
				state_d = svo_pkg::ST_FIN;
			end
			svo_pkg::ST_FIN: begin
				if (rsp_load) begin
					state_d = svo_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = svo_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svo_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q        <= svo_pkg::PASS_LEVEL;
			cnt_q         <= '0;
			phase_acc_q   <= '0;
			phase_step_q  <= '0;
			release_env_q <= '0;
			note_level_q  <= '0;
			voice_on_q    <= 1'b0;
			waveform_q    <= svo_pkg::WAVE_SINE;
			output_gain_q <= svo_pkg::GAIN_RESET;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (svo_pkg::cfg_idx_t'(cfg_idx))
					svo_pkg::CFG_WAVEFORM: begin
						waveform_q <= svo_pkg::wave_t'(cfg_wdata[svo_pkg::WAVE_W-1:0]);
					end
					svo_pkg::CFG_OUTPUT_GAIN: begin
						output_gain_q <= cfg_wdata[svo_pkg::GAIN_W-1:0];
					end
				endcase
			end

			if (req_accept) begin
				unique case (op)
					svo_pkg::OP_TICK: begin
						if (voice_on_q) begin
							phase_acc_q <= phase_acc_q + phase_step_q;
						end
					end
					svo_pkg::OP_NOTE_ON: begin
						note_level_q  <= svo_pkg::LEVEL_TABLE[req.velocity];
						phase_step_q  <= svo_pkg::STEP_TABLE[req.note];
						phase_acc_q   <= '0;
						release_env_q <= '0;
						voice_on_q    <= 1'b1;
					end
					svo_pkg::OP_NOTE_OFF: begin
						if (voice_on_q) begin
							release_env_q <= svo_pkg::ENV_START;
						end
					end
					svo_pkg::OP_NOTE_KILL: begin
						voice_on_q    <= 1'b0;
						phase_step_q  <= '0;
						release_env_q <= '0;
					end
				endcase
			end

			if (tick_accept) begin
				pass_q <= svo_pkg::PASS_LEVEL;
				cnt_q  <= svo_pkg::CNT_W'(svo_pkg::LEVEL_DIGITS - 1);
			end else if (state_q == svo_pkg::ST_MUL) begin
				if (!last_digit) begin
					cnt_q <= cnt_q - 1'b1;
				end else if (pass_q == svo_pkg::PASS_LEVEL) begin
					pass_q <= svo_pkg::PASS_ENV;
					cnt_q  <= svo_pkg::CNT_W'(svo_pkg::ENV_DIGITS - 1);
				end else if (pass_q == svo_pkg::PASS_ENV) begin
					pass_q <= svo_pkg::PASS_GAIN;
					cnt_q  <= svo_pkg::CNT_W'(svo_pkg::GAIN_DIGITS - 1);
				end
			end else if (state_q == svo_pkg::ST_ROUND) begin
				pass_q <= svo_pkg::PASS_DECAY;
				cnt_q  <= svo_pkg::CNT_W'(svo_pkg::DECAY_DIGITS - 1);
			end

			if (state_q == svo_pkg::ST_ENV) begin
				if (decayed < svo_pkg::ENV_FLOOR) begin
					release_env_q <= '0;
					phase_step_q  <= '0;
					voice_on_q    <= 1'b0;
				end else begin
					release_env_q <= decayed;
				end
			end

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_accept) begin
			acc_q        <= '0;
			mcand_q      <= svo_pkg::PROD_W'(wave_mag);
			neg_q        <= wave_neg;
			mplier_q     <= svo_pkg::MPLIER_W'(note_level_q);
			res_sample_q <= '0;
		end else if (state_q == svo_pkg::ST_MUL) begin
			if (last_digit && pass_q == svo_pkg::PASS_LEVEL) begin
				acc_q    <= '0;
				mcand_q  <= acc_nx;
				mplier_q <= env_eff;
			end else if (last_digit && pass_q == svo_pkg::PASS_ENV) begin
				acc_q    <= '0;
				mcand_q  <= acc_nx;
				mplier_q <= svo_pkg::MPLIER_W'(output_gain_q);
			end else begin
				acc_q    <= acc_nx;
				mcand_q  <= mcand_q << svo_pkg::DIGIT_W;
				mplier_q <= mplier_q >> svo_pkg::DIGIT_W;
			end
		end else if (state_q == svo_pkg::ST_ROUND) begin
			res_sample_q <= round_sample;
			acc_q        <= svo_pkg::ENV_HALF;
			mcand_q      <= svo_pkg::PROD_W'(release_env_q);
			mplier_q     <= svo_pkg::MPLIER_W'(svo_pkg::ENV_DECAY);
		end

		if (rsp_load) begin
			rsp_sample_q <= res_sample_q;
			rsp_active_q <= voice_on_q;
		end
	end

	assign req.ready  = req_ready;
	assign rsp.valid  = rsp_valid_q;
	assign rsp.sample = $signed(rsp_sample_q);
	assign rsp.active = rsp_active_q;

`ifndef SYNTH
	a_idle_voice_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!voice_on_q |-> (phase_step_q == '0 && release_env_q == '0))
		else $error("silent voice keeps an increment or envelope");

	a_env_above_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(release_env_q != '0) |-> (release_env_q >= svo_pkg::ENV_FLOOR))
		else $error("release envelope below floor");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == svo_pkg::ST_FIN))
		else $error("result beat not loaded from the finish state");

	a_digit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == svo_pkg::ST_MUL) |-> (cnt_q < svo_pkg::CNT_W'(svo_pkg::ENV_DIGITS)))
		else $error("multiplier digit count out of range");
`endif

endmodule
